// ----- rtl/shc_pkg.sv -----
// Package for the strip hit clusterer: widths, codes, limits and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
package shc_pkg;

  localparam int LAYER_STRIPS = 1536;

  localparam int STRIP_W = 11;
  localparam int SPLIT_W = 12;
  localparam int TOT_W   = 8;
  localparam int TALLY_W = 11;
  localparam int SIDE_W  = 2;
  localparam int LADDER_W = 11;

  // Signed compare width for strip arithmetic against the split strip.
  localparam int CMP_W = SPLIT_W + 1;
  // Cluster span can reach 2048, which needs one bit more than a strip.
  localparam int SPAN_W = STRIP_W + 1;
  localparam int PROD_W = TOT_W + SPAN_W;
  localparam int DIVIDEND_W = PROD_W + 1;

  localparam int REM_STEPS = STRIP_W;
  localparam int DIV_STEPS = DIVIDEND_W;
  localparam int CNT_W = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam int TALLY_CAP = (LAYER_STRIPS < 2047) ? LAYER_STRIPS : 2047;
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(TALLY_CAP);
  localparam logic [TALLY_W-1:0] MAX_BAD = TALLY_W'(10);
  localparam logic [TOT_W-1:0] NO_TOT = 8'd255;

  localparam logic KIND_STRIP = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic MODE_STANDARD = 1'b0;
  localparam logic MODE_BAD      = 1'b1;

  localparam logic [LADDER_W-1:0] LADDER_RESET = 11'd384;

  typedef enum logic {
    CFG_CLUSTER_MODE  = 1'b0,
    CFG_LADDER_STRIPS = 1'b1
  } cfg_reg_t;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_LOW  = 2'd0,
    SIDE_HIGH = 2'd1,
    SIDE_BOTH = 2'd2
  } side_t;

  typedef struct packed {
    logic load;       // capture the accepted input item
    logic rem_start;  // begin strip modulo ladder size
    logic rem_step;
    logic eval;       // judge the open cluster, register products
    logic div_start;  // begin weighted ToT division
    logic div_step;
    logic out_write;  // load the output register
    logic update;     // apply the item to the open cluster
  } shc_cmd_t;

  typedef struct packed {
    logic need_rem;   // ladder boundary check needs the remainder
    logic close;      // the item closes the open cluster
    logic report;     // the closed cluster is emitted
    logic needs_div;  // the ToT needs the weighted division
    logic out_free;   // the output register can take a result
  } shc_status_t;

endpackage

// ----- rtl/shc_ctrl.sv -----
// Sequencer for the strip hit clusterer: steps each accepted item through
// the ladder check, cluster judgment, ToT division and output write.
// Depends on shc_pkg.
module shc_ctrl
  import shc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  shc_status_t status,
  output shc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REM,
    ST_CLOSE,
    ST_JUDGE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.need_rem) begin
          cmd.rem_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_REM;
        end else begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_REM: begin
        cmd.rem_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(REM_STEPS - 1)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (status.close) begin
          cmd.eval  = 1'b1;
          state_nxt = ST_JUDGE;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_JUDGE: begin
        if (!status.report) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (status.needs_div) begin
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.out_write = 1'b1;
          cmd.update    = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/shc_datapath.sv -----
// Datapath of the strip hit clusterer: configuration registers, open
// cluster state, ladder remainder unit, ToT divider and output register.
// Depends on shc_pkg.
module shc_datapath
  import shc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [LADDER_W-1:0]   cfg_data,
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  shc_cmd_t              cmd,
  output shc_status_t           status
);

  // Configuration.
  logic                mode_r;
  logic [LADDER_W-1:0] ladder_r;

  // Accepted item.
  logic                      it_kind_r;
  logic [STRIP_W-1:0]        it_strip_r;
  logic                      it_bad_r;
  logic signed [SPLIT_W-1:0] it_split_r;
  logic [TOT_W-1:0]          it_tlo_r;
  logic [TOT_W-1:0]          it_thi_r;

  // Open cluster.
  logic                      have_r;
  logic [STRIP_W-1:0]        first_r;
  logic [STRIP_W-1:0]        last_r;
  logic [TALLY_W-1:0]        tally_r;
  logic signed [SPLIT_W-1:0] hsplit_r;
  logic [TOT_W-1:0]          htlo_r;
  logic [TOT_W-1:0]          hthi_r;

  // Remainder unit.
  logic [LADDER_W-1:0] rem_r;
  logic [STRIP_W-1:0]  rsh_r;

  // Judged cluster.
  logic [STRIP_W-1:0] res_first_r;
  logic [STRIP_W-1:0] res_last_r;
  logic [TALLY_W-1:0] res_bad_r;
  logic [SIDE_W-1:0]  res_side_r;
  logic [TOT_W-1:0]   res_tot_r;
  logic               report_r;
  logic               needs_div_r;
  logic [PROD_W-1:0]  plo_r;
  logic [PROD_W-1:0]  phi_r;
  logic [SPAN_W-1:0]  span_r;

  // Divider.
  logic [SPAN_W-1:0]     drem_r;
  logic [DIVIDEND_W-1:0] dsh_r;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Closing decision.
  logic [STRIP_W:0] last_inc;
  logic             need_rem;
  logic             gap;
  logic             close;

  assign last_inc = {1'b0, last_r} + (STRIP_W + 1)'(1);
  assign need_rem = have_r && (it_kind_r == KIND_STRIP) && (mode_r == MODE_STANDARD)
                    && (ladder_r != '0) && ({1'b0, it_strip_r} == last_inc);
  assign gap      = ({1'b0, it_strip_r} > last_inc) || (need_rem && (rem_r == '0));
  assign close    = have_r && ((it_kind_r == KIND_END) || gap);

  // Remainder step.
  logic [LADDER_W:0] rem_t;
  logic [LADDER_W:0] rem_d;

  assign rem_t = {rem_r, rsh_r[STRIP_W-1]};
  assign rem_d = (rem_t >= {1'b0, ladder_r}) ? (rem_t - {1'b0, ladder_r}) : rem_t;

  // Cluster judgment.
  logic signed [CMP_W-1:0] first_s, last_s, split_s, span_s, tally_s, wlo_s, whi_s;
  logic                    too_bad;
  side_t                   side;
  logic                    tot_ok;
  logic [TOT_W-1:0]        side_tot;

  always_comb begin
    first_s = $signed({2'b00, first_r});
    last_s  = $signed({2'b00, last_r});
    split_s = $signed({hsplit_r[SPLIT_W-1], hsplit_r});
    tally_s = $signed({2'b00, tally_r});
    span_s  = last_s - first_s + CMP_W'(1);
    wlo_s   = split_s - first_s + CMP_W'(1);
    whi_s   = last_s - split_s;
    too_bad = (span_s <= tally_s) || (tally_r > MAX_BAD);
    if (first_s <= split_s) begin
      side = (last_s <= split_s) ? SIDE_LOW : SIDE_BOTH;
    end else begin
      side = SIDE_HIGH;
    end
    tot_ok = (htlo_r != NO_TOT) && (hthi_r != NO_TOT);
    unique case (side)
      SIDE_LOW:  side_tot = htlo_r;
      SIDE_HIGH: side_tot = hthi_r;
      default:   side_tot = NO_TOT;
    endcase
  end

  // Divider step.
  logic [SPAN_W:0] div_t;
  logic            div_ge;
  logic [SPAN_W:0] div_d;

  assign div_t  = {drem_r, dsh_r[DIVIDEND_W-1]};
  assign div_ge = div_t >= {1'b0, span_r};
  assign div_d  = div_ge ? (div_t - {1'b0, span_r}) : div_t;

  logic [TOT_W-1:0] final_tot;
  assign final_tot = needs_div_r ? dsh_r[TOT_W-1:0] : res_tot_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STANDARD;
      ladder_r    <= LADDER_RESET;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_CLUSTER_MODE:  mode_r   <= cfg_data[0];
          CFG_LADDER_STRIPS: ladder_r <= cfg_data;
        endcase
      end
      if (cmd.update) begin
        have_r <= (it_kind_r == KIND_STRIP);
      end
      if (cmd.out_write) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_kind_r  <= in_tuser;
      it_strip_r <= in_tdata[10:0];
      it_bad_r   <= in_tdata[11];
      it_split_r <= $signed(in_tdata[23:12]);
      it_tlo_r   <= in_tdata[31:24];
      it_thi_r   <= in_tdata[39:32];
    end
    if (cmd.rem_start) begin
      rem_r <= '0;
      rsh_r <= it_strip_r;
    end else if (cmd.rem_step) begin
      rem_r <= rem_d[LADDER_W-1:0];
      rsh_r <= {rsh_r[STRIP_W-2:0], 1'b0};
    end
    if (cmd.eval) begin
      res_first_r <= first_r;
      res_last_r  <= last_r;
      res_bad_r   <= tally_r;
      res_side_r  <= (mode_r == MODE_BAD) ? SIDE_LOW : side;
      res_tot_r   <= (mode_r == MODE_BAD) ? '0 : side_tot;
      report_r    <= (mode_r == MODE_BAD) || !too_bad;
      needs_div_r <= (mode_r == MODE_STANDARD) && (side == SIDE_BOTH) && tot_ok;
      plo_r       <= PROD_W'(htlo_r) * PROD_W'(wlo_s[SPAN_W-1:0]);
      phi_r       <= PROD_W'(hthi_r) * PROD_W'(whi_s[SPAN_W-1:0]);
      span_r      <= span_s[SPAN_W-1:0];
    end
    if (cmd.div_start) begin
      drem_r <= '0;
      dsh_r  <= DIVIDEND_W'(plo_r) + DIVIDEND_W'(phi_r);
    end else if (cmd.div_step) begin
      drem_r <= div_d[SPAN_W-1:0];
      dsh_r  <= {dsh_r[DIVIDEND_W-2:0], div_ge};
    end
    if (cmd.out_write) begin
      out_data_r <= {5'b00000, final_tot, res_side_r, res_bad_r, res_last_r, res_first_r};
    end
    if (cmd.update && (it_kind_r == KIND_END)) begin
      tally_r <= '0;
    end else if (cmd.update) begin
      if (close || !have_r) begin
        first_r <= it_strip_r;
        tally_r <= TALLY_W'(it_bad_r);
      end else if (it_bad_r && (tally_r < TALLY_MAX)) begin
        tally_r <= tally_r + TALLY_W'(1);
      end
      last_r   <= it_strip_r;
      hsplit_r <= it_split_r;
      htlo_r   <= it_tlo_r;
      hthi_r   <= it_thi_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    status.need_rem  = need_rem;
    status.close     = close;
    status.report    = report_r;
    status.needs_div = needs_div_r;
    status.out_free  = !out_valid_r || out_tready;
  end

endmodule

// ----- rtl/strip_hit_clusterer_core.sv -----
// Top level of the strip hit clusterer: sequencer plus datapath.
// Depends on shc_pkg, shc_ctrl and shc_datapath.
//
// The block takes one layer's strips in ascending order, each marked good
// or bad, followed by an end-of-layer item, and groups contiguous strips
// into clusters. A cluster closes on a gap, on the end-of-layer item, and in
// standard mode also at a ladder boundary. In standard mode a cluster is
// sent out only if it has a good strip and at most ten bad strips, and it
// carries its readout side and a raw ToT, width-weighted when it straddles
// the split strip (255 if either side has none). In bad-cluster mode every
// cluster is sent out with side and ToT of zero. Items are handled one at a
// time: each passes the ladder check, through the 11-step modulo unit when
// the ladder boundary has to be checked; an item that closes a cluster is
// then judged and, unless the cluster is dropped, written to the output
// register, a straddling ToT first going through the bit-serial divider.
// The next input transfer is taken only once all of this is done, plus any
// wait for the output register to drain. The result sits in an output
// register, so the next input transfer is taken while it waits; only a
// second result waits for the first to drain. Configuration writes are
// always ready and must come while the block is idle.
module strip_hit_clusterer_core
  import shc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [LADDER_W-1:0]   cfg_data,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata, lowest bit first: strip[10:0], is_bad[11], split_strip[23:12],
  // tot_low[31:24], tot_high[39:32].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: kind (0 strip, 1 end of layer).
  input  logic                  in_tuser,
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata, lowest bit first: first_strip[10:0], last_strip[21:11],
  // bad_count[32:22], end_side[34:33], raw_tot[42:35], zero fill [47:43].
  output logic [OUT_DATA_W-1:0] out_tdata
);

  shc_cmd_t    cmd;
  shc_status_t status;

  // Registers are plain flops with no side effects, so writes never stall.
  assign cfg_ready = 1'b1;

  shc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  shc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

  // A reported side is one of low, high or straddling, never the unused code.
  a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:33] != 2'd3))
    else $error("result carries an unused side code");

  // The bad tally saturates, so no result can exceed the cap.
  a_bad_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:22] <= TALLY_MAX))
    else $error("bad count above saturation limit");

  // The open cluster is never updated in the cycle a new item is taken in.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !cmd.update)
    else $error("item accepted while the previous one is still applied");

  // A result is written only after the cluster was judged to be reported.
  a_write_reported: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_write |-> status.report)
    else $error("output written for a rejected cluster");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for strip_hit_clusterer_core: stream driver, result
// monitor and a cycle-free cluster predictor built into one top module.
// Depends on shc_pkg and the strip_hit_clusterer_core RTL.
module tb;
  import shc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // This many cycles of quiet are enough for a trailing item with no result
  // to finish its work.
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int SATURATE_ITEMS = 1540;

  // One input item as the predictor sees it. The split strip is kept as raw
  // bits and sign-extended where it is compared.
  typedef struct packed {
    logic               kind;
    logic [STRIP_W-1:0] strip;
    logic               bad;
    logic [SPLIT_W-1:0] split;
    logic [TOT_W-1:0]   tot_lo;
    logic [TOT_W-1:0]   tot_hi;
  } strip_item_t;

  // One reported cluster.
  typedef struct packed {
    logic [STRIP_W-1:0] first;
    logic [STRIP_W-1:0] last;
    logic [TALLY_W-1:0] nbad;
    side_t              side;
    logic [TOT_W-1:0]   tot;
  } cluster_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [LADDER_W-1:0]   cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  strip_hit_clusterer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Items waiting to be driven, and clusters the predictor says must come out.
  strip_item_t strip_feed[$];
  cluster_t    expected_clusters[$];

  // Predictor copy of the registers and the open cluster, at reset values.
  logic               cl_mode = MODE_STANDARD;
  logic [LADDER_W-1:0] ladder_size = LADDER_RESET;
  logic               cl_open = 1'b0;
  logic [STRIP_W-1:0] cl_first = '0;
  logic [STRIP_W-1:0] cl_last = '0;
  logic [TALLY_W-1:0] cl_bad = '0;
  logic signed [SPLIT_W-1:0] cl_split = '0;
  logic [TOT_W-1:0]   cl_tot_lo = NO_TOT;
  logic [TOT_W-1:0]   cl_tot_hi = NO_TOT;

  int errors = 0;
  int items_sent = 0;
  int clusters_checked = 0;
  int settings_used = 1;
  int side_tally[3] = '{0, 0, 0};
  int bad_mode_clusters = 0;

  // Judges the open cluster as it closes. Returns 1 and fills the result when
  // the cluster is reported. Standard mode drops clusters with no good strip
  // (which also covers a last strip below the first) or with more than ten
  // bad strips; bad-strip mode reports everything with side and ToT zero.
  function automatic bit judge_cluster(output cluster_t res);
    int first_i, last_i, split_i, span;
    first_i = cl_first;
    last_i = cl_last;
    split_i = int'(cl_split);
    res.first = cl_first;
    res.last = cl_last;
    res.nbad = cl_bad;
    res.side = SIDE_LOW;
    res.tot = '0;
    if (cl_mode == MODE_BAD) return 1'b1;
    if (last_i - first_i + 1 <= int'(cl_bad)) return 1'b0;
    if (cl_bad > MAX_BAD) return 1'b0;
    if (first_i > split_i) begin
      res.side = SIDE_HIGH;
      res.tot = cl_tot_hi;
    end else if (last_i <= split_i) begin
      res.side = SIDE_LOW;
      res.tot = cl_tot_lo;
    end else begin
      // The cluster straddles the split: weight each side by its width.
      res.side = SIDE_BOTH;
      if (cl_tot_lo != NO_TOT && cl_tot_hi != NO_TOT) begin
        span = last_i - first_i + 1;
        res.tot = TOT_W'((int'(cl_tot_lo) * (split_i - first_i + 1) +
                          int'(cl_tot_hi) * (last_i - split_i)) / span);
      end else begin
        res.tot = NO_TOT;
      end
    end
    return 1'b1;
  endfunction

  function automatic void close_cluster();
    cluster_t res;
    if (judge_cluster(res)) begin
      expected_clusters = {expected_clusters, res};
      if (cl_mode == MODE_BAD) bad_mode_clusters++;
      else side_tally[res.side]++;
    end
  endfunction

  // Applies one accepted item to the predicted cluster state.
  function automatic void cluster_track(strip_item_t it);
    bit brk;
    if (it.kind == KIND_END) begin
      if (cl_open) close_cluster();
      cl_open = 1'b0;
      cl_bad = '0;
      return;
    end
    if (cl_open) begin
      // A repeated or lower strip is not a gap and simply extends the cluster.
      brk = it.strip > cl_last + 1;
      if (!brk && cl_mode == MODE_STANDARD && ladder_size != 0 &&
          (cl_last / ladder_size) < (it.strip / ladder_size))
        brk = 1'b1;
      if (brk) begin
        close_cluster();
        cl_open = 1'b0;
      end
    end
    if (!cl_open) begin
      cl_open = 1'b1;
      cl_first = it.strip;
      cl_bad = '0;
    end
    cl_last = it.strip;
    if (it.bad && cl_bad < TALLY_MAX) cl_bad++;
    // Split and ToTs are latched after the closing decision above.
    cl_split = it.split;
    cl_tot_lo = it.tot_lo;
    cl_tot_hi = it.tot_hi;
  endfunction

  function automatic void add_item(logic kind, int strip, logic bad, int split,
                                   int tlo, int thi);
    strip_item_t it;
    it.kind = kind;
    it.strip = STRIP_W'(strip);
    it.bad = bad;
    it.split = SPLIT_W'(split);
    it.tot_lo = TOT_W'(tlo);
    it.tot_hi = TOT_W'(thi);
    strip_feed = {strip_feed, it};
  endfunction

  // An end-of-layer item carries random junk in the fields it does not use.
  function automatic void add_end();
    add_item(KIND_END, $urandom_range(0, LAYER_STRIPS - 1), $urandom_range(0, 1),
             int'($urandom_range(0, LAYER_STRIPS)) - 1, $urandom_range(0, 255),
             $urandom_range(0, 255));
  endfunction

  function automatic int pick_split(int pos);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return -1;
    if (pick == 2) return LAYER_STRIPS - 1;
    if (pick < 7) return (pos + 20 < LAYER_STRIPS) ? pos + $urandom_range(0, 20)
                                                   : LAYER_STRIPS - 1;
    return $urandom_range(0, LAYER_STRIPS - 1);
  endfunction

  function automatic int pick_tot();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return NO_TOT;
    if (pick < 5) return 0;
    if (pick == 5) return 254;
    return $urandom_range(0, 255);
  endfunction

  // Builds one layer: ascending runs of contiguous strips with random gaps,
  // runs placed just below ladder boundaries now and then, a few repeated or
  // lower strips, stray end items mid-layer, and now and then no closing end.
  // Returns the number of items queued.
  function automatic int add_random_layer();
    int n, pos, run, i, bad_pct, split_v, tlo, thi, k, lower;
    n = 0;
    case ($urandom_range(0, 3))
      0: bad_pct = 0;
      1: bad_pct = 5;
      2: bad_pct = 30;
      default: bad_pct = 90;
    endcase
    pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, LAYER_STRIPS - 1)
                                       : $urandom_range(0, 40);
    split_v = pick_split(pos);
    tlo = pick_tot();
    thi = pick_tot();
    while (pos < LAYER_STRIPS && n < 40) begin
      if (ladder_size != 0 && $urandom_range(0, 4) == 0) begin
        k = (pos / ladder_size + 1) * ladder_size - $urandom_range(1, 3);
        if (k > pos && k < LAYER_STRIPS) pos = k;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 4);
      for (i = 0; i < run && pos < LAYER_STRIPS; i++) begin
        if ($urandom_range(0, 9) == 0) split_v = pick_split(pos);
        if ($urandom_range(0, 3) == 0) begin
          tlo = pick_tot();
          thi = pick_tot();
        end
        if (n > 0 && $urandom_range(0, 29) == 0) begin
          lower = pos - 1 - $urandom_range(0, 2);
          if (lower < 0) lower = 0;
          add_item(KIND_STRIP, lower, $urandom_range(0, 99) < bad_pct, split_v, tlo, thi);
        end else begin
          add_item(KIND_STRIP, pos, $urandom_range(0, 99) < bad_pct, split_v, tlo, thi);
          pos++;
        end
        n++;
      end
      if ($urandom_range(0, 29) == 0) begin
        add_end();
        n++;
      end
      // pos already sits one past the last strip, so any step here is a gap.
      pos += $urandom_range(1, 30);
    end
    if ($urandom_range(0, 19) != 0) begin
      add_end();
      n++;
    end
    return n;
  endfunction

  // Driver. A new item is put up whenever the bus is free or the current one
  // is taken; bursts of random length alternate with random gaps, and some
  // bursts run with no gap at all. The predictor runs on each transfer.
  strip_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cluster_track(cur_item);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (strip_feed.size() > 0) begin
          cur_item = strip_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_item.tot_hi, cur_item.tot_lo, cur_item.split,
                       cur_item.bad, cur_item.strip};
          in_tuser <= cur_item.kind;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 1) == 0) gap_left = 0;
            else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(20, 40);
            else gap_left = $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver. The first waiting result after reset, and now and then a later
  // one, starts a long hold so that the output register and then the core
  // fill up and the input side stalls while the directed items are still
  // being offered.
  int rx_cycle = 0;
  int rx_style = 0;
  int hold_left = 0;
  int next_hold_at = 0;
  int holds_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left == 0 && out_tvalid && rx_cycle >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at = rx_cycle + 25000;
        holds_done++;
      end
      if (rx_cycle % 48 == 0) rx_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= rx_cycle[0];
        endcase
      end
    end
  end

  // Monitor. Every result transfer is matched against the oldest prediction,
  // field by field, and the zero fill above the ToT is checked as well.
  always @(posedge clk) begin
    cluster_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_clusters.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected cluster: first %0d last %0d bad %0d side %0d tot %0d",
                   out_tdata[10:0], out_tdata[21:11], out_tdata[32:22],
                   out_tdata[34:33], out_tdata[42:35]);
      end else begin
        want = expected_clusters.pop_front();
        clusters_checked++;
        if (out_tdata[10:0] !== want.first || out_tdata[21:11] !== want.last ||
            out_tdata[32:22] !== want.nbad || out_tdata[34:33] !== want.side ||
            out_tdata[42:35] !== want.tot || out_tdata[47:43] !== '0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("cluster %0d mismatch: expected first %0d last %0d bad %0d side %0d tot %0d",
                     clusters_checked, want.first, want.last, want.nbad, want.side,
                     want.tot);
            $display("  got first %0d last %0d bad %0d side %0d tot %0d fill %0h",
                     out_tdata[10:0], out_tdata[21:11], out_tdata[32:22],
                     out_tdata[34:33], out_tdata[42:35], out_tdata[47:43]);
          end
        end
      end
    end
  end

  // Waits until every queued item is taken and every predicted cluster has
  // come out, then lets the core finish any item that produces nothing.
  task automatic wait_idle();
    while (strip_feed.size() != 0 || in_tvalid || expected_clusters.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LADDER_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CLUSTER_MODE) cl_mode = value[0];
    else ladder_size = value;
    cfg_valid <= 1'b0;
  endtask

  // Drains the core, writes both registers, then queues random layers.
  task automatic run_phase(input logic mode, input int ladder, input int target);
    int n;
    wait_idle();
    write_reg(CFG_CLUSTER_MODE, LADDER_W'(mode));
    write_reg(CFG_LADDER_STRIPS, LADDER_W'(ladder));
    settings_used++;
    n = 0;
    while (n < target) n += add_random_layer();
  endtask

  initial begin
    int n, i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings: standard mode, 384 per ladder.
    // An end of layer with no open cluster produces nothing.
    add_item(KIND_END, LAYER_STRIPS - 1, 1'b1, -1, NO_TOT, NO_TOT);
    // A low-side cluster with one bad strip.
    add_item(KIND_STRIP, 0, 1'b0, 5, 0, NO_TOT);
    add_item(KIND_STRIP, 1, 1'b1, 5, 0, NO_TOT);
    add_item(KIND_STRIP, 2, 1'b0, 5, 0, NO_TOT);
    // A cluster straddling the split with both ToTs measured.
    add_item(KIND_STRIP, 100, 1'b0, 101, 40, 200);
    add_item(KIND_STRIP, 101, 1'b1, 101, 40, 200);
    add_item(KIND_STRIP, 102, 1'b0, 101, 40, 200);
    add_item(KIND_STRIP, 103, 1'b0, 101, 40, 200);
    // A straddling cluster where the low side has no ToT.
    add_item(KIND_STRIP, 200, 1'b0, 200, NO_TOT, 30);
    add_item(KIND_STRIP, 201, 1'b0, 200, NO_TOT, 30);
    // A high-side cluster with the split at minus one.
    add_item(KIND_STRIP, 300, 1'b0, -1, 9, 77);
    // Two neighboring strips on either side of a ladder boundary.
    add_item(KIND_STRIP, 383, 1'b0, LAYER_STRIPS - 1, 12, 0);
    add_item(KIND_STRIP, 384, 1'b0, LAYER_STRIPS - 1, 12, 0);
    // A cluster of only bad strips is dropped.
    add_item(KIND_STRIP, 500, 1'b1, 0, 1, 2);
    add_item(KIND_STRIP, 501, 1'b1, 0, 1, 2);
    // A repeated and then a lower strip join the cluster, which ends below
    // its first strip and is dropped.
    add_item(KIND_STRIP, 600, 1'b0, 0, 3, 4);
    add_item(KIND_STRIP, 600, 1'b0, 0, 3, 4);
    add_item(KIND_STRIP, 598, 1'b1, 0, 3, 4);
    add_item(KIND_END, 0, 1'b0, 0, 0, 0);
    // The top of the layer with no ToT on either side.
    add_item(KIND_STRIP, 1534, 1'b0, LAYER_STRIPS - 1, NO_TOT, NO_TOT);
    add_item(KIND_STRIP, 1535, 1'b0, LAYER_STRIPS - 1, NO_TOT, NO_TOT);
    add_item(KIND_END, 0, 1'b0, 0, 0, 0);
    // A two-strip straddle with extreme ToTs.
    add_item(KIND_STRIP, 1023, 1'b0, 1023, 254, 1);
    add_item(KIND_STRIP, 1024, 1'b0, 1023, 254, 1);
    add_item(KIND_END, 0, 1'b0, 0, 0, 0);
    n = 0;
    while (n < 40) n += add_random_layer();

    // Every strip is its own ladder, then one ladder for the whole layer,
    // then no ladder boundary at all.
    run_phase(MODE_STANDARD, 1, 20);
    run_phase(MODE_STANDARD, LAYER_STRIPS, 20);
    run_phase(MODE_STANDARD, 0, 20);

    // Bad-strip cluster list, where ladder boundaries do not apply.
    run_phase(MODE_BAD, 384, 20);
    run_phase(MODE_BAD, 1, 20);
    // One long cluster of a single repeated bad strip drives the bad tally
    // into saturation.
    add_end();
    for (i = 0; i < SATURATE_ITEMS; i++)
      add_item(KIND_STRIP, 700, 1'b1, pick_split(700), pick_tot(), pick_tot());
    add_end();

    run_phase(MODE_STANDARD, $urandom_range(2, LAYER_STRIPS - 1), 20);
    run_phase(MODE_STANDARD, LADDER_RESET, 20);

    wait_idle();
    $display("Drove %0d transfers over %0d register settings with %0d long receiver holds.",
             items_sent, settings_used, holds_done);
    $display("Checked %0d clusters: %0d low side, %0d high side, %0d straddling, %0d bad-strip.",
             clusters_checked, side_tally[SIDE_LOW], side_tally[SIDE_HIGH],
             side_tally[SIDE_BOTH], bad_mode_clusters);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb NOT OK");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including every long hold.
  initial begin
    #30_000_000;
    $display("timeout with %0d clusters still expected", expected_clusters.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/shc_pkg.sv
rtl/shc_ctrl.sv
rtl/shc_datapath.sv
rtl/strip_hit_clusterer_core.sv
test/tb.sv
